/* rtl/dltq_pkg.sv */
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types, constants and helpers for the delta-list timeout queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned DELTA_W  = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned TICK_W   = 24;
  localparam int unsigned ENTRY_W  = DELTA_W + HANDLE_W;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_SCHED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef enum logic {
    REQ_SCHEDULE = 1'b0,
    REQ_ADVANCE  = 1'b1
  } req_e;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    walk_adv;
    logic    shift_start;
    logic    shift_step;
    logic    insert;
    logic    pop;
    logic    head_wb;
    logic    res_load;
    status_e res_code;
    logic    out_prev;
    logic    out_final;
  } dltq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic noop;
    logic walk_cont;
    logic pos_lt_cnt;
    logic shift_last;
    logic pop_ok;
    logic pend;
    logic slot_free;
  } dltq_sts_t;

  // logical list position -> physical slot of the circular store
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lpos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(lpos);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

/* rtl/dltq_ram.sv */
// ----------------------------------------------------------------------------
// dltq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dltq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dltq_ctrl.sv */
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer: walk, shift and insert for schedule; pop loop for advance.
// ----------------------------------------------------------------------------
module dltq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_i,
  output logic              in_ready_o,
  input  dltq_pkg::dltq_sts_t sts_i,
  output dltq_pkg::dltq_cmd_t cmd_o
);
  import dltq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WALK   = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_INSERT = 6'b001000,
    S_HEAD   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.res_code = ST_SCHED;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_req_i == REQ_SCHEDULE) begin
            if (sts_i.full) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = ST_FULL;
              state_d        = S_EMIT;
            end else begin
              state_d = S_WALK;
            end
          end else if (sts_i.noop) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = ST_NONE;
            state_d        = S_EMIT;
          end else begin
            state_d = S_HEAD;
          end
        end
      end
      S_WALK: begin
        if (sts_i.walk_cont) begin
          cmd_o.walk_adv = 1'b1;
        end else if (sts_i.pos_lt_cnt) begin
          cmd_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end else begin
          state_d = S_INSERT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_last) begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd_o.insert   = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = ST_SCHED;
        state_d        = S_EMIT;
      end
      S_HEAD: begin
        if (sts_i.pop_ok) begin
          // the previous pop goes out first, so it needs a free slot
          if (!sts_i.pend || sts_i.slot_free) begin
            cmd_o.pop      = 1'b1;
            cmd_o.out_prev = sts_i.pend;
          end
        end else begin
          cmd_o.head_wb  = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = sts_i.pend ? ST_EXPIRED : ST_NONE;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.out_final = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

/* rtl/dltq_dp.sv */
// ----------------------------------------------------------------------------
// dltq_dp
// Datapath: circular entry store, walk/shift counters, delta arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module dltq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dltq_pkg::TICK_W-1:0]   in_delay_i,
  input  logic [dltq_pkg::HANDLE_W-1:0] in_handle_i,
  input  logic [dltq_pkg::TICK_W-1:0]   in_elapsed_i,
  input  dltq_pkg::dltq_cmd_t           cmd_i,
  output dltq_pkg::dltq_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_status_o,
  output logic [dltq_pkg::HANDLE_W-1:0] out_handle_o,
  output logic                          out_last_o
);
  import dltq_pkg::*;

  // control registers
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] j_q, j_d;
  logic [NW-1:0] n_q, n_d;
  logic          first_q, first_d;
  logic          pend_q, pend_d;
  logic          ovld_q, ovld_d;

  // payload registers
  logic [TICK_W-1:0]   ticks_q;
  logic [HANDLE_W-1:0] hdl_q;
  logic [TICK_W-1:0]   el_q;
  logic [HANDLE_W-1:0] pend_hdl_q;
  status_e             res_q;
  status_e             ostat_q;
  logic [HANDLE_W-1:0] ohdl_q;
  logic                olast_q;

  // store
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  logic signed [DELTA_W-1:0] rd_delta;
  logic [HANDLE_W-1:0]       rd_hdl;
  logic signed [DELTA_W:0]   rd_delta_x, ticks_x, sub_x;
  logic signed [DELTA_W-1:0] dn, shift_delta;
  logic                      dn_le0, d_pos, shift_last, slot_free;
  logic [TICK_W-1:0]         clamp;

  assign rd_delta = rdata[ENTRY_W-1:HANDLE_W];
  assign rd_hdl   = rdata[HANDLE_W-1:0];

  assign rd_delta_x = {rd_delta[DELTA_W-1], rd_delta};
  assign ticks_x    = {{(DELTA_W + 1 - TICK_W){1'b0}}, ticks_q};

  // head delta after the elapsed ticks, saturating at the negative end
  assign sub_x = rd_delta_x - {{(DELTA_W + 1 - TICK_W){1'b0}}, el_q};
  always_comb begin
    if (!first_q) begin
      dn = rd_delta;
    end else if (sub_x[DELTA_W] != sub_x[DELTA_W-1]) begin
      dn = {1'b1, {(DELTA_W - 1){1'b0}}};
    end else begin
      dn = sub_x[DELTA_W-1:0];
    end
  end
  assign dn_le0 = dn[DELTA_W-1] || (dn == '0);

  assign d_pos       = !rd_delta[DELTA_W-1] && (rd_delta != '0);
  assign shift_last  = (j_q == CW'(pos_q + 1'b1));
  assign shift_delta = rd_delta - DELTA_W'(ticks_x);
  assign slot_free   = !ovld_q || out_ready_i;

  // non-positive delays become one tick
  assign clamp = (in_delay_i[TICK_W-1] || (in_delay_i == '0)) ? TICK_W'(1) : in_delay_i;

  always_comb begin
    sts_o.full       = (cnt_q == CW'(QUEUE_DEPTH));
    sts_o.noop       = (in_elapsed_i == '0) || (cnt_q == '0);
    sts_o.pos_lt_cnt = (pos_q < cnt_q);
    sts_o.walk_cont  = (pos_q < cnt_q) && (ticks_x > rd_delta_x);
    sts_o.shift_last = shift_last;
    sts_o.pop_ok     = (cnt_q != '0) && dn_le0 && (n_q < NW'(MAX_RESULTS));
    sts_o.pend       = pend_q;
    sts_o.slot_free  = slot_free;
  end

  // read address: next entry the sequencer will look at
  always_comb begin
    raddr = head_q;
    if (cmd_i.walk_adv) begin
      raddr = phys(head_q, CW'(pos_q + 1'b1));
    end else if (cmd_i.shift_start) begin
      raddr = phys(head_q, CW'(cnt_q - 1'b1));
    end else if (cmd_i.shift_step && !shift_last) begin
      raddr = phys(head_q, CW'(j_q - CW'(2)));
    end else if (cmd_i.pop) begin
      raddr = phys(head_q, CW'(1));
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = head_q;
    wdata = rdata;
    if (cmd_i.shift_step) begin
      we    = 1'b1;
      waddr = phys(head_q, j_q);
      // the entry displaced by the new one gives up the new delay
      wdata = shift_last ? {shift_delta, rd_hdl} : rdata;
    end else if (cmd_i.insert) begin
      we    = 1'b1;
      waddr = phys(head_q, pos_q);
      wdata = {DELTA_W'(ticks_x), hdl_q};
    end else if (cmd_i.head_wb && first_q) begin
      we    = 1'b1;
      waddr = head_q;
      wdata = {dn, rd_hdl};
    end
  end

  dltq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    j_d     = j_q;
    n_d     = n_q;
    first_d = first_q;
    pend_d  = pend_q;
    ovld_d  = ovld_q;
    if (cmd_i.accept) begin
      pos_d   = '0;
      n_d     = '0;
      first_d = 1'b1;
      pend_d  = 1'b0;
    end
    if (cmd_i.walk_adv) begin
      pos_d = CW'(pos_q + 1'b1);
    end
    if (cmd_i.shift_start) begin
      j_d = cnt_q;
    end
    if (cmd_i.shift_step) begin
      j_d = CW'(j_q - 1'b1);
    end
    if (cmd_i.insert) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end
    if (cmd_i.pop) begin
      head_d  = phys(head_q, CW'(1));
      cnt_d   = CW'(cnt_q - 1'b1);
      n_d     = NW'(n_q + 1'b1);
      first_d = 1'b0;
      pend_d  = 1'b1;
    end
    if (cmd_i.out_prev || cmd_i.out_final) begin
      ovld_d = 1'b1;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      j_q     <= '0;
      n_q     <= '0;
      first_q <= 1'b0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      j_q     <= j_d;
      n_q     <= n_d;
      first_q <= first_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ticks_q <= clamp;
      hdl_q   <= in_handle_i;
      el_q    <= in_elapsed_i;
    end
    if (cmd_i.walk_adv && d_pos) begin
      // delta is below ticks here, so it fits the tick width
      ticks_q <= ticks_q - rd_delta[TICK_W-1:0];
    end
    if (cmd_i.pop) begin
      pend_hdl_q <= rd_hdl;
    end
    if (cmd_i.res_load) begin
      res_q <= cmd_i.res_code;
    end
    if (cmd_i.out_prev) begin
      ostat_q <= ST_EXPIRED;
      ohdl_q  <= pend_hdl_q;
      olast_q <= 1'b0;
    end else if (cmd_i.out_final) begin
      ostat_q <= res_q;
      ohdl_q  <= (res_q == ST_EXPIRED) ? pend_hdl_q : '0;
      olast_q <= 1'b1;
    end
  end

  assign out_valid_o  = ovld_q;
  assign out_status_o = ostat_q;
  assign out_handle_o = ohdl_q;
  assign out_last_o   = olast_q;

endmodule

/* rtl/delta_list_timeout_queue.sv */
// ----------------------------------------------------------------------------
// delta_list_timeout_queue
// Timer queue kept as a delta list of relative delays and callback handles.
// ----------------------------------------------------------------------------
// Usage: requests enter on s_axis one at a time; tuser selects a schedule (0)
//   or an advance of time (1). A schedule stores a handle at its sorted place
//   and answers with one response (scheduled or queue full). An advance
//   subtracts the elapsed ticks from the head, then pops every head entry that
//   is due, up to 16 per request, one expired response each; the last carries
//   tlast. With nothing due, one 'none expired' response.
// Steps (no stalls):
//   Schedule walks the list one entry at a time, moves the entries behind
//   its place down in the store, then inserts and responds. A schedule into a
//   full queue, or an advance on an empty queue or by zero ticks, responds
//   without touching the store. Any other advance pops the due entries one at
//   a time, then responds. One read and one write port on the entry store set one list step per cycle.
// Reset: the queue comes up empty; stored deltas and handles are not cleared.
// Backpressure: responses sit in an output register; a stalled m_axis side
//   holds the sequencer only when a further response must be written. A new
//   request is taken as soon as the last response is in that register.
// ----------------------------------------------------------------------------
module delta_list_timeout_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [23:0] delay_ticks, [39:24] callback_handle, [63:40] elapsed_ticks
  input  logic [63:0] s_axis_tdata_i,
  // [0] req_type
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] expired_handle
  output logic [15:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import dltq_pkg::*;

  dltq_cmd_t cmd;
  dltq_sts_t sts;

  // sequencer: owns the request handshake and all decisions
  dltq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_req_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: store, counters, arithmetic and response register
  dltq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_delay_i   (s_axis_tdata_i[23:0]),
    .in_handle_i  (s_axis_tdata_i[39:24]),
    .in_elapsed_i (s_axis_tdata_i[63:40]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_handle_o (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule
